@@ design/two_sample_background_model_unit_defines.svh @@
// ----------------------------------------------------------------------------
// two_sample_background_model_unit_defines.svh
// Assertion macros for the two-sample background model unit.
// ----------------------------------------------------------------------------
`ifndef TWO_SAMPLE_BACKGROUND_MODEL_UNIT_DEFINES_SVH
`define TWO_SAMPLE_BACKGROUND_MODEL_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset
`define TSBM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tsbm assertion failed");

// Check that a condition is followed by a consequence in the next cycle
`define TSBM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tsbm assertion failed");

`else

`define TSBM_ASSERT(lbl, prop)
`define TSBM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ design/tsbm_pkg.sv @@
// ----------------------------------------------------------------------------
// tsbm_pkg
// Shared types and constants of the two-sample background model unit.
// ----------------------------------------------------------------------------
package tsbm_pkg;

  // Operation codes carried by one input transaction
  typedef enum logic [1:0] {
    OP_INIT    = 2'd0,
    OP_SEGMENT = 2'd1,
    OP_UPDATE  = 2'd2
  } op_e;

  // Spread around the pixel value written at init
  localparam logic [7:0] INIT_MARGIN    = 8'd10;
  // Reset value of the matching threshold
  localparam logic [7:0] THRESHOLD_RST  = 8'd20;
  // Largest grey level
  localparam logic [7:0] SAMPLE_MAX     = 8'd255;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;   // latch the input transaction
    logic wr_init;   // write both samples of the own pixel
    logic wr_update; // write the picked sample of the own pixel
    logic rd_own;    // read both samples of the own pixel
    logic eval;      // count matching samples
    logic rd_nb;     // read both samples of the neighbor
    logic wr_nb;     // write one sample of the neighbor
    logic load_out;  // move the count into the output register
  } cmd_t;

endpackage

@@ design/two_sample_background_model_unit.sv @@
// ----------------------------------------------------------------------------
// two_sample_background_model_unit: two-sample per-pixel background model
// Init writes both samples; segment reads them, then counts matches; update
// writes one sample, then reads and writes the neighbor if propagating. One item
// at a time: the next transaction is taken after the result loads.
// Reset clears control and sets the threshold to 20; memories are not cleared.
// ----------------------------------------------------------------------------
`include "two_sample_background_model_unit_defines.svh"

module two_sample_background_model_unit #(
  parameter int unsigned PIXELS = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] pixel_index_i,
  input  logic [7:0]  pixel_value_i,
  input  logic        update_mask_i,
  input  logic        pick_second_i,
  input  logic        propagate_i,
  input  logic [15:0] neighbor_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  match_count_o
);

  tsbm_pkg::cmd_t cmd;

  // Sequence control
  tsbm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .op_i          (op_i),
    .update_mask_i (update_mask_i),
    .propagate_i   (propagate_i),
    .out_stall_i   (out_stall_i),
    .in_stall_o    (in_stall_o),
    .out_valid_o   (out_valid_o),
    .cmd_o         (cmd)
  );

  // Memories and arithmetic
  tsbm_datapath #(
    .Pixels (PIXELS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .op_i             (op_i),
    .pixel_index_i    (pixel_index_i),
    .pixel_value_i    (pixel_value_i),
    .pick_second_i    (pick_second_i),
    .neighbor_index_i (neighbor_index_i),
    .match_count_o    (match_count_o)
  );

  // Busy right after a transaction is taken
  `TSBM_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  // At most one datapath command at a time
  `TSBM_ASSERT(a_cmd_onehot, $onehot0(cmd))
  // A new result only comes from an output load
  `TSBM_ASSERT(a_out_from_load, $rose(out_valid_o) |-> $past(cmd.load_out))

endmodule

@@ design/tsbm_ctrl.sv @@
// ----------------------------------------------------------------------------
// tsbm_ctrl
// Controller: sequences memory accesses for each transaction and owns the
// input and output handshakes.
// ----------------------------------------------------------------------------
module tsbm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        op_i,
  input  logic              update_mask_i,
  input  logic              propagate_i,
  input  logic              out_stall_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  output tsbm_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT_WR,
    ST_SEG_RD,
    ST_SEG_EVAL,
    ST_UPD_WR,
    ST_NB_RD,
    ST_NB_WR,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;
  logic   out_valid_q, out_valid_d;
  logic   prop_q, prop_d;
  logic   accept;
  logic   slot_free;

  assign accept    = in_valid_i && !busy_q;
  assign slot_free = !out_valid_q || !out_stall_i;

  // Next state and output register control
  always_comb begin
    state_d     = state_q;
    prop_d      = prop_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          prop_d = propagate_i;
          case (op_i)
            tsbm_pkg::OP_INIT:    state_d = ST_INIT_WR;
            tsbm_pkg::OP_SEGMENT: state_d = ST_SEG_RD;
            tsbm_pkg::OP_UPDATE:  state_d = update_mask_i ? ST_UPD_WR : ST_FINISH;
            default:              state_d = ST_FINISH;
          endcase
        end
      end
      ST_INIT_WR:  state_d = ST_FINISH;
      ST_SEG_RD:   state_d = ST_SEG_EVAL;
      ST_SEG_EVAL: state_d = ST_FINISH;
      ST_UPD_WR:   state_d = prop_q ? ST_NB_RD : ST_FINISH;
      ST_NB_RD:    state_d = ST_NB_WR;
      ST_NB_WR:    state_d = ST_FINISH;
      ST_FINISH: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Hold state and registered handshake outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      prop_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      busy_q      <= (state_d != ST_IDLE);
      out_valid_q <= out_valid_d;
      prop_q      <= prop_d;
    end
  end

  // Decode datapath commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.capture   = accept;
    cmd_o.wr_init   = (state_q == ST_INIT_WR);
    cmd_o.rd_own    = (state_q == ST_SEG_RD);
    cmd_o.eval      = (state_q == ST_SEG_EVAL);
    cmd_o.wr_update = (state_q == ST_UPD_WR);
    cmd_o.rd_nb     = (state_q == ST_NB_RD);
    cmd_o.wr_nb     = (state_q == ST_NB_WR);
    cmd_o.load_out  = (state_q == ST_FINISH) && slot_free;
  end

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;

endmodule

@@ design/tsbm_datapath.sv @@
// ----------------------------------------------------------------------------
// tsbm_datapath
// Datapath: sample memories, transaction registers, threshold register,
// match counting and neighbor selection.
// ----------------------------------------------------------------------------
module tsbm_datapath #(
  parameter int unsigned Pixels = 65536
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tsbm_pkg::cmd_t    cmd_i,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_data_i,
  input  logic [1:0]        op_i,
  input  logic [15:0]       pixel_index_i,
  input  logic [7:0]        pixel_value_i,
  input  logic              pick_second_i,
  input  logic [15:0]       neighbor_index_i,
  output logic [1:0]        match_count_o
);

  localparam int unsigned AddrW = (Pixels > 1) ? $clog2(Pixels) : 1;

  // Sample memories
  logic [7:0] mem_first  [Pixels];
  logic [7:0] mem_second [Pixels];

  // Transaction registers
  logic [1:0]  op_q;
  logic [15:0] pix_q;
  logic [7:0]  val_q;
  logic        sel_q;
  logic [15:0] nb_q;

  logic [7:0]  thr_q;
  logic [7:0]  rd_first_q, rd_second_q;
  logic        rd_inrange_q;
  logic [1:0]  count_q;
  logic [1:0]  match_count_q;

  logic [31:0]      pix_ext, nb_ext;
  logic             pix_inrange, nb_inrange;
  logic [AddrW-1:0] pix_addr, nb_addr;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic             wr_inrange, rd_inrange;
  logic             rd_en;
  logic [7:0]       h1, h2;
  logic [7:0]       init_lo, init_hi;
  logic             nb_to_first;
  logic             first_we, second_we;
  logic [7:0]       first_wd, second_wd;
  logic [7:0]       spread, thr_eff, dist1, dist2;
  logic [1:0]       count_d;

  // Capture the input transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_i;
      pix_q <= pixel_index_i;
      val_q <= pixel_value_i;
      sel_q <= pick_second_i;
      nb_q  <= neighbor_index_i;
    end
  end

  // Hold the matching threshold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= tsbm_pkg::THRESHOLD_RST;
    end else if (cfg_we_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // Map indexes onto the store and flag those beyond it
  assign pix_ext     = 32'(pix_q);
  assign nb_ext      = 32'(nb_q);
  assign pix_inrange = pix_ext < 32'(Pixels);
  assign nb_inrange  = nb_ext < 32'(Pixels);
  assign pix_addr    = pix_ext[AddrW-1:0];
  assign nb_addr     = nb_ext[AddrW-1:0];

  assign wr_addr    = cmd_i.wr_nb ? nb_addr : pix_addr;
  assign wr_inrange = cmd_i.wr_nb ? nb_inrange : pix_inrange;
  assign rd_addr    = cmd_i.rd_nb ? nb_addr : pix_addr;
  assign rd_inrange = cmd_i.rd_nb ? nb_inrange : pix_inrange;
  assign rd_en      = cmd_i.rd_own || cmd_i.rd_nb;

  // Samples read beyond the store count as zero
  assign h1 = rd_inrange_q ? rd_first_q  : 8'd0;
  assign h2 = rd_inrange_q ? rd_second_q : 8'd0;

  // Init bounds, clamped to the grey range
  assign init_lo = (val_q >= tsbm_pkg::INIT_MARGIN) ? val_q - tsbm_pkg::INIT_MARGIN : 8'd0;
  assign init_hi = (val_q > tsbm_pkg::SAMPLE_MAX - tsbm_pkg::INIT_MARGIN) ?
                   tsbm_pkg::SAMPLE_MAX : val_q + tsbm_pkg::INIT_MARGIN;

  // Neighbor takes the value in its first sample when 2v < h1 + h2
  assign nb_to_first = ({val_q, 1'b0}) < ({1'b0, h1} + {1'b0, h2});

  // Write port steering
  assign first_we  = wr_inrange && (cmd_i.wr_init || (cmd_i.wr_update && !sel_q) ||
                                    (cmd_i.wr_nb && nb_to_first));
  assign second_we = wr_inrange && (cmd_i.wr_init || (cmd_i.wr_update && sel_q) ||
                                    (cmd_i.wr_nb && !nb_to_first));
  assign first_wd  = cmd_i.wr_init ? init_lo : val_q;
  assign second_wd = cmd_i.wr_init ? init_hi : val_q;

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (first_we) begin
      mem_first[wr_addr] <= first_wd;
    end
    if (rd_en) begin
      rd_first_q <= mem_first[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (second_we) begin
      mem_second[wr_addr] <= second_wd;
    end
    if (rd_en) begin
      rd_second_q  <= mem_second[rd_addr];
      rd_inrange_q <= rd_inrange;
    end
  end

  // Adaptive threshold and match count
  assign spread  = (h2 >= h1) ? h2 - h1 : h1 - h2;
  assign thr_eff = (spread < thr_q) ? thr_q : spread;
  assign dist1   = (val_q >= h1) ? val_q - h1 : h1 - val_q;
  assign dist2   = (val_q >= h2) ? val_q - h2 : h2 - val_q;
  assign count_d = {1'b0, dist1 <= thr_eff} + {1'b0, dist2 <= thr_eff};

  // Count is zero for anything but a segment transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      count_q <= 2'd0;
    end else if (cmd_i.eval && (op_q == tsbm_pkg::OP_SEGMENT)) begin
      count_q <= count_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      match_count_q <= count_q;
    end
  end

  assign match_count_o = match_count_q;

endmodule
